/* rtl/ppls_pkg.sv */
// shared widths and types for the point projection pipeline
package ppls_pkg;

  localparam int CoordBits = 24;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int NumBits   = ProdBits + 1;
  localparam int MagBits   = ProdBits;
  localparam int DenBits   = ProdBits;
  localparam int TBits     = 32;
  localparam int TFrac     = 16;
  localparam int DivSteps  = TBits;
  localparam int TdBits    = TBits + DiffBits;
  localparam int RndBits   = TdBits - TFrac;
  localparam int SumBits   = RndBits + 1;

  typedef enum logic [1:0] {
    OpLine    = 2'd0,
    OpRay     = 2'd1,
    OpSegment = 2'd2,
    OpSegAlt  = 2'd3
  } opcode_e;

  // per-item context carried down the pipe
  typedef struct packed {
    logic                          seg;
    logic                          ray;
    logic [2:0][CoordBits-1:0]     b;
    logic [2:0][DiffBits-1:0]      d;
  } ctx_t;

endpackage

/* rtl/point_projection_line_ray_segment.sv */
// top level: pipelined closest point on a 3d line, ray or segment
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+--------------------------------------
//  input   | in_valid_i   | in_ready_o   | opcode_i, point_*_i, base_*_i, second_*_i
//  output  | out_valid_o  | out_ready_i  | proj_*_o, param_t_o, degenerate_o
//
// one beat per cycle sustained while the output is not stalled; the pipe has
// four set-up stages, a 32-stage restoring divider (one quotient bit per stage)
// and three stages for clamp, t*d multiply and round/saturate.
// reset clears only the stage valid bits.
// when the output register holds a beat that is not taken, the whole pipe
// holds and in_ready_o drops; nothing is lost or repeated.
module point_projection_line_ray_segment (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            opcode_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] point_x_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] point_y_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] point_z_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] base_x_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] base_y_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] base_z_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] second_x_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] second_y_i,
  input  logic signed [ppls_pkg::CoordBits-1:0] second_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ppls_pkg::CoordBits-1:0] proj_x_o,
  output logic signed [ppls_pkg::CoordBits-1:0] proj_y_o,
  output logic signed [ppls_pkg::CoordBits-1:0] proj_z_o,
  output logic signed [ppls_pkg::TBits-1:0]     param_t_o,
  output logic                                  degenerate_o
);

  localparam int CB = ppls_pkg::CoordBits;
  localparam int DB = ppls_pkg::DiffBits;
  localparam int PB = ppls_pkg::ProdBits;
  localparam int NB = ppls_pkg::NumBits;
  localparam int MB = ppls_pkg::MagBits;
  localparam int EB = ppls_pkg::DenBits;
  localparam int TB = ppls_pkg::TBits;
  localparam int TF = ppls_pkg::TFrac;
  localparam int NS = ppls_pkg::DivSteps;
  localparam int XB = ppls_pkg::TdBits;
  localparam int RB = ppls_pkg::RndBits;
  localparam int SB = ppls_pkg::SumBits;

  logic en;

  // whole pipe advances unless the output beat is stalled
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage a: differences
  logic                    a_v_q;
  ppls_pkg::ctx_t          a_ctx_q, a_ctx_d;
  logic [2:0][DB-1:0]      a_e_q, a_e_d;

  always_comb begin
    logic signed [CB-1:0] p [3];
    logic signed [CB-1:0] bb [3];
    logic signed [CB-1:0] s [3];
    p[0] = point_x_i;  p[1] = point_y_i;  p[2] = point_z_i;
    bb[0] = base_x_i;  bb[1] = base_y_i;  bb[2] = base_z_i;
    s[0] = second_x_i; s[1] = second_y_i; s[2] = second_z_i;
    a_ctx_d.seg = opcode_i[1];
    a_ctx_d.ray = (opcode_i == ppls_pkg::OpRay);
    for (int i = 0; i < 3; i++) begin
      a_ctx_d.b[i] = bb[i];
      a_ctx_d.d[i] = opcode_i[1] ? (DB'(s[i]) - DB'(bb[i])) : DB'(s[i]);
      a_e_d[i]     = DB'(p[i]) - DB'(bb[i]);
    end
  end

  // ---------------- stage b: products
  logic                    b_v_q;
  ppls_pkg::ctx_t          b_ctx_q;
  logic [2:0][PB-1:0]      b_pe_q, b_pe_d, b_pd_q, b_pd_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_pe_d[i] = PB'($signed(a_e_q[i]) * $signed(a_ctx_q.d[i]));
      b_pd_d[i] = PB'($signed(a_ctx_q.d[i]) * $signed(a_ctx_q.d[i]));
    end
  end

  // ---------------- stage c: dot product and length squared
  logic                    c_v_q;
  ppls_pkg::ctx_t          c_ctx_q;
  logic [MB-1:0]           c_mag_q, c_mag_d;
  logic                    c_neg_q, c_neg_d;
  logic [EB-1:0]           c_den_q, c_den_d;

  always_comb begin
    logic signed [NB-1:0] num;
    logic signed [NB-1:0] anum;
    num = NB'($signed(b_pe_q[0])) + NB'($signed(b_pe_q[1])) + NB'($signed(b_pe_q[2]));
    c_neg_d = num[NB-1];
    anum    = c_neg_d ? -num : num;
    c_mag_d = anum[MB-1:0];
    c_den_d = b_pd_q[0] + b_pd_q[1] + b_pd_q[2];
  end

  // ---------------- stage d and divider stages
  logic               dv_v_q   [NS+1];
  ppls_pkg::ctx_t     dv_ctx_q [NS+1];
  logic [EB-1:0]      dv_rem_q [NS+1];
  logic [EB-1:0]      dv_den_q [NS+1];
  logic [TB-1:0]      dv_quo_q [NS+1];
  logic [TB-1:0]      dv_low_q [NS+1];
  logic               dv_neg_q [NS+1];
  logic               dv_ovf_q [NS+1];
  logic               dv_deg_q [NS+1];

  logic [MB+TF-1:0]   d_lhs, d_rhs;

  // quotient of 2^32 or more saturates whatever the sign
  assign d_lhs = (MB+TF)'(c_mag_q);
  assign d_rhs = {c_den_q, {TF{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      c_v_q     <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      a_v_q     <= in_valid_i;
      b_v_q     <= a_v_q;
      c_v_q     <= b_v_q;
      dv_v_q[0] <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctx_q     <= a_ctx_d;
      a_e_q       <= a_e_d;
      b_ctx_q     <= a_ctx_q;
      b_pe_q      <= b_pe_d;
      b_pd_q      <= b_pd_d;
      c_ctx_q     <= b_ctx_q;
      c_mag_q     <= c_mag_d;
      c_neg_q     <= c_neg_d;
      c_den_q     <= c_den_d;
      dv_ctx_q[0] <= c_ctx_q;
      dv_rem_q[0] <= EB'(c_mag_q[MB-1:TB-TF]);
      dv_low_q[0] <= {c_mag_q[TB-TF-1:0], {TF{1'b0}}};
      dv_den_q[0] <= c_den_q;
      dv_quo_q[0] <= '0;
      dv_neg_q[0] <= c_neg_q;
      dv_ovf_q[0] <= (d_lhs >= d_rhs);
      dv_deg_q[0] <= (c_den_q == '0);
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [EB:0]   r2;
    logic [EB:0]   diff;
    logic          ge;
    logic [EB-1:0] rem_d;

    always_comb begin
      r2    = {dv_rem_q[k], dv_low_q[k][TB-1]};
      diff  = r2 - {1'b0, dv_den_q[k]};
      ge    = (r2 >= {1'b0, dv_den_q[k]});
      rem_d = ge ? diff[EB-1:0] : r2[EB-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_ctx_q[k+1] <= dv_ctx_q[k];
        dv_rem_q[k+1] <= rem_d;
        dv_low_q[k+1] <= {dv_low_q[k][TB-2:0], 1'b0};
        dv_den_q[k+1] <= dv_den_q[k];
        dv_quo_q[k+1] <= {dv_quo_q[k][TB-2:0], ge};
        dv_neg_q[k+1] <= dv_neg_q[k];
        dv_ovf_q[k+1] <= dv_ovf_q[k];
        dv_deg_q[k+1] <= dv_deg_q[k];
      end
    end
  end

  // ---------------- stage e: sign, saturation and clamp of t
  logic                   e_v_q;
  ppls_pkg::ctx_t         e_ctx_q;
  logic signed [TB-1:0]   e_t_q, e_t_d;
  logic                   e_deg_q;

  always_comb begin
    logic [TB-1:0] q;
    logic signed [TB-1:0] t;
    q = dv_quo_q[NS];
    if (!dv_neg_q[NS]) begin
      t = (dv_ovf_q[NS] || q[TB-1]) ? {1'b0, {(TB-1){1'b1}}} : q;
    end else begin
      t = (dv_ovf_q[NS] || (q > {1'b1, {(TB-1){1'b0}}})) ? {1'b1, {(TB-1){1'b0}}} : -q;
    end
    if ((dv_ctx_q[NS].ray || dv_ctx_q[NS].seg) && t[TB-1]) begin
      t = '0;
    end
    if (dv_ctx_q[NS].seg && (t > $signed(TB'(1) << TF))) begin
      t = $signed(TB'(1) << TF);
    end
    // zero direction: t forced to zero gives the base point back
    e_t_d = dv_deg_q[NS] ? '0 : t;
  end

  // ---------------- stage f: t times direction
  logic                   f_v_q;
  ppls_pkg::ctx_t         f_ctx_q;
  logic signed [TB-1:0]   f_t_q;
  logic                   f_deg_q;
  logic [2:0][XB-1:0]     f_td_q, f_td_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_td_d[i] = XB'(e_t_q * $signed(e_ctx_q.d[i]));
    end
  end

  // ---------------- stage g: round, add base, saturate
  logic                   g_v_q;
  logic [2:0][CB-1:0]     g_proj_q, g_proj_d;
  logic signed [TB-1:0]   g_t_q;
  logic                   g_deg_q;

  always_comb begin
    logic signed [XB-1:0] r;
    logic signed [RB-1:0] sh;
    logic signed [SB-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      r   = $signed(f_td_q[i]) + $signed(XB'(1) << (TF - 1));
      sh  = RB'(r >>> TF);
      sum = SB'(sh) + SB'($signed(f_ctx_q.b[i]));
      if (sum > $signed(SB'({1'b0, {(CB-1){1'b1}}}))) begin
        g_proj_d[i] = {1'b0, {(CB-1){1'b1}}};
      end else if (sum < -$signed(SB'({1'b1, {(CB-1){1'b0}}}))) begin
        g_proj_d[i] = {1'b1, {(CB-1){1'b0}}};
      end else begin
        g_proj_d[i] = sum[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
    end else if (en) begin
      e_v_q <= dv_v_q[NS];
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_ctx_q  <= dv_ctx_q[NS];
      e_t_q    <= e_t_d;
      e_deg_q  <= dv_deg_q[NS];
      f_ctx_q  <= e_ctx_q;
      f_t_q    <= e_t_q;
      f_deg_q  <= e_deg_q;
      f_td_q   <= f_td_d;
      g_proj_q <= g_proj_d;
      g_t_q    <= f_t_q;
      g_deg_q  <= f_deg_q;
    end
  end

  assign out_valid_o  = g_v_q;
  assign proj_x_o     = g_proj_q[0];
  assign proj_y_o     = g_proj_q[1];
  assign proj_z_o     = g_proj_q[2];
  assign param_t_o    = g_t_q;
  assign degenerate_o = g_deg_q;

endmodule

/* rtl/ppls_checker.sv */
// port-level checks for the point projection pipeline, bound to the top level
module ppls_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [ppls_pkg::CoordBits-1:0] proj_x_o,
  input logic signed [ppls_pkg::TBits-1:0]     param_t_o,
  input logic                                  degenerate_o
);

  // stalled result beat stays
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(proj_x_o) && $stable(param_t_o))
    else $error("stalled result beat changed");

  // empty output register never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output empty");

  // a stalled result stalls the whole pipe
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  // zero direction reports zero t
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> param_t_o == '0)
    else $error("degenerate beat with nonzero t");

endmodule

bind point_projection_line_ray_segment ppls_checker u_ppls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .proj_x_o     (proj_x_o),
  .param_t_o    (param_t_o),
  .degenerate_o (degenerate_o)
);

/* sim/testbench.sv */
// self-checking testbench for the line, ray and segment point projection pipeline
module testbench;

  localparam int CoordBits = ppls_pkg::CoordBits;
  localparam int TBits     = ppls_pkg::TBits;
  localparam int TFrac     = ppls_pkg::TFrac;

  typedef struct {
    logic [1:0]                  op;
    logic signed [CoordBits-1:0] pt [3];
    logic signed [CoordBits-1:0] base [3];
    logic signed [CoordBits-1:0] sec [3];
  } query_t;

  typedef struct {
    logic signed [CoordBits-1:0] proj [3];
    logic signed [TBits-1:0]     t;
    logic                        degen;
  } proj_t;

  localparam int Latency = 39;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = ppls_pkg::OpLine;
  logic signed [CoordBits-1:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [CoordBits-1:0] base_x_i = '0, base_y_i = '0, base_z_i = '0;
  logic signed [CoordBits-1:0] second_x_i = '0, second_y_i = '0, second_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CoordBits-1:0] proj_x_o, proj_y_o, proj_z_o;
  logic signed [TBits-1:0] param_t_o;
  logic degenerate_o;

  query_t pending_q [$];
  proj_t  expected_q [$];
  int     fail_cnt = 0;
  int     send_idle = 0;
  int     recv_stall = 0;
  bit     hold_send = 1'b0;
  bit     stim_done = 1'b0;

  point_projection_line_ray_segment u_top (.*);

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // saturate a wide signed value to the coordinate range
  function automatic logic signed [CoordBits-1:0] sat_coord(logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (CoordBits - 1)) - 1;
    lo = -(128'sd1 <<< (CoordBits - 1));
    if (v > hi) return hi[CoordBits-1:0];
    if (v < lo) return lo[CoordBits-1:0];
    return v[CoordBits-1:0];
  endfunction

  // closest point prediction, exact wide arithmetic
  function automatic proj_t project(query_t q);
    proj_t r;
    logic signed [127:0] d [3];
    logic signed [127:0] num, den, mag, quo, t, v;
    bit seg, ray;
    seg = q.op[1];
    ray = (q.op == ppls_pkg::OpRay);
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = seg ? 128'(q.sec[i]) - 128'(q.base[i]) : 128'(q.sec[i]);
      num += (128'(q.pt[i]) - 128'(q.base[i])) * d[i];
      den += d[i] * d[i];
    end
    if (den == 0) begin
      for (int i = 0; i < 3; i++) r.proj[i] = q.base[i];
      r.t = '0;
      r.degen = 1'b1;
      return r;
    end
    mag = (num < 0) ? -num : num;
    quo = (mag <<< TFrac) / den;
    if (num >= 0) t = (quo > 128'sh7FFFFFFF) ? 128'sh7FFFFFFF : quo;
    else t = (quo > 128'sh80000000) ? -128'sh80000000 : -quo;
    if ((ray || seg) && t < 0) t = 0;
    if (seg && t > (128'sd1 <<< TFrac)) t = 128'sd1 <<< TFrac;
    for (int i = 0; i < 3; i++) begin
      v = ((t * d[i] + (128'sd1 <<< (TFrac - 1))) >>> TFrac) + 128'(q.base[i]);
      r.proj[i] = sat_coord(v);
    end
    r.t = t[TBits-1:0];
    r.degen = 1'b0;
    return r;
  endfunction

  function automatic logic signed [CoordBits-1:0] rand_coord(int mode);
    case (mode)
      0: return CoordBits'($urandom);
      1: return CoordBits'($signed($urandom_range(0, 8191)) - 4096);
      2: return $urandom_range(0, 1) ? {1'b0, {(CoordBits-1){1'b1}}}
                                      : {1'b1, {(CoordBits-1){1'b0}}};
      default: return CoordBits'($signed($urandom_range(0, 600000)) - 300000);
    endcase
  endfunction

  task automatic push_query(logic [1:0] op, logic signed [CoordBits-1:0] p,
                            logic signed [CoordBits-1:0] b,
                            logic signed [CoordBits-1:0] s);
    query_t q;
    q.op = op;
    for (int i = 0; i < 3; i++) begin
      q.pt[i] = p;
      q.base[i] = b;
      q.sec[i] = s;
    end
    pending_q.push_back(q);
  endtask

  // driver: one beat per handshake, holds payload while waiting
  always @(posedge clk_i) begin
    query_t q;
    bit take;
    if (rst_ni) begin
      take = !in_valid_i || in_ready_o;
      if (take) begin
        if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
          in_valid_i <= 1'b0;
        end else if (!hold_send && pending_q.size() > 0) begin
          q = pending_q.pop_front();
          expected_q.push_back(project(q));
          in_valid_i <= 1'b1;
          opcode_i <= q.op;
          point_x_i <= q.pt[0];
          point_y_i <= q.pt[1];
          point_z_i <= q.pt[2];
          base_x_i <= q.base[0];
          base_y_i <= q.base[1];
          base_z_i <= q.base[2];
          second_x_i <= q.sec[0];
          second_y_i <= q.sec[1];
          second_z_i <= q.sec[2];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each output beat with the oldest prediction
  always @(posedge clk_i) begin
    proj_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected beat: proj %0d %0d %0d t %0d", $time,
                   proj_x_o, proj_y_o, proj_z_o, param_t_o);
          fail_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (proj_x_o !== e.proj[0] || proj_y_o !== e.proj[1] || proj_z_o !== e.proj[2]
              || param_t_o !== e.t || degenerate_o !== e.degen) begin
            $display("%0t mismatch: expected %0d %0d %0d t %0d deg %0b", $time,
                     e.proj[0], e.proj[1], e.proj[2], e.t, e.degen);
            $display("%0t           actual   %0d %0d %0d t %0d deg %0b", $time,
                     proj_x_o, proj_y_o, proj_z_o, param_t_o, degenerate_o);
            fail_cnt++;
          end
        end
      end
      out_ready_i <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
    end
  end

  // stimulus phases
  initial begin
    query_t q;
    int     mode;
    logic signed [CoordBits-1:0] maxc, minc;
    maxc = {1'b0, {(CoordBits-1){1'b1}}};
    minc = {1'b1, {(CoordBits-1){1'b0}}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, each opcode, zero direction, clamping
    push_query(ppls_pkg::OpLine, 24'sd4096, 24'sd0, 24'sd4096);
    push_query(ppls_pkg::OpRay, -24'sd4096, 24'sd0, 24'sd4096);
    push_query(ppls_pkg::OpSegment, 24'sd8192, 24'sd0, 24'sd4096);
    push_query(ppls_pkg::OpSegAlt, -24'sd8192, 24'sd0, 24'sd4096);
    push_query(ppls_pkg::OpLine, maxc, minc, 24'sd1);
    push_query(ppls_pkg::OpLine, minc, maxc, 24'sd1);
    push_query(ppls_pkg::OpLine, maxc, 24'sd0, 24'sd0);
    push_query(ppls_pkg::OpSegment, maxc, 24'sd100, 24'sd100);
    push_query(ppls_pkg::OpRay, maxc, minc, maxc);
    push_query(ppls_pkg::OpSegment, minc, minc, maxc);
    push_query(ppls_pkg::OpLine, maxc, maxc, minc);
    push_query(ppls_pkg::OpLine, -24'sd1, -24'sd1, -24'sd1);
    push_query(ppls_pkg::OpRay, 24'sd1, 24'sd0, 24'sd3);
    push_query(ppls_pkg::OpLine, 24'sd2048, 24'sd0, 24'sd4096);
    push_query(ppls_pkg::OpSegAlt, 24'sd0, 24'sd0, 24'sd0);
    push_query(ppls_pkg::OpRay, 24'sd0, 24'sd0, 24'sd0);

    // random phases with differing idle and stall pressure
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        3: begin send_idle = 22; recv_stall = 22; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int n = 0; n < 160; n++) begin
        q.op = 2'($urandom_range(0, 3));
        mode = $urandom_range(0, 7);
        for (int i = 0; i < 3; i++) begin
          q.pt[i] = rand_coord(mode % 4);
          q.base[i] = rand_coord(mode % 4);
          q.sec[i] = rand_coord((mode + 1) % 4);
        end
        if ($urandom_range(0, 19) == 0) begin
          for (int i = 0; i < 3; i++) q.sec[i] = q.op[1] ? q.base[i] : '0;
        end
        pending_q.push_back(q);
      end
      while (pending_q.size() > 0) @(posedge clk_i);
      // drain fully once, holding the sender off
      if (ph == 1) begin
        hold_send = 1'b1;
        while (expected_q.size() > 0) @(posedge clk_i);
        hold_send = 1'b0;
      end
    end
    stim_done = 1'b1;
  end

  // end of run
  initial begin
    wait (stim_done);
    while (expected_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
